// ===== design/kabf_pkg.sv =====
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, constants and helpers for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int REG_W = 31;
  localparam int DATA_W = 32;
  localparam int DT_W = 17;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_NOISE_ANGLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_NOISE_BIAS = 2'd1;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

  // Operand selection codes for the shared multiplier.
  localparam logic [3:0] MUL_DT_RATE = 4'd0;
  localparam logic [3:0] MUL_DT_BB = 4'd1;
  localparam logic [3:0] MUL_DT_T = 4'd2;
  localparam logic [3:0] MUL_QB_DT = 4'd3;
  localparam logic [3:0] MUL_K0_INNOV = 4'd4;
  localparam logic [3:0] MUL_K1_INNOV = 4'd5;
  localparam logic [3:0] MUL_K0_AA = 4'd6;
  localparam logic [3:0] MUL_K0_AB = 4'd7;
  localparam logic [3:0] MUL_K1_AA = 4'd8;
  localparam logic [3:0] MUL_K1_AB = 4'd9;

  // Datapath step codes.
  localparam logic [4:0] OP_NONE = 5'd0;
  localparam logic [4:0] OP_LOAD = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_ANGLE_P = 5'd3;
  localparam logic [4:0] OP_PRED_T = 5'd4;
  localparam logic [4:0] OP_AA_P = 5'd5;
  localparam logic [4:0] OP_BB_P = 5'd6;
  localparam logic [4:0] OP_S = 5'd7;
  localparam logic [4:0] OP_DIV0_START = 5'd8;
  localparam logic [4:0] OP_DIV_STEP = 5'd9;
  localparam logic [4:0] OP_K0 = 5'd10;
  localparam logic [4:0] OP_DIV1_START = 5'd11;
  localparam logic [4:0] OP_K1 = 5'd12;
  localparam logic [4:0] OP_INNOV = 5'd13;
  localparam logic [4:0] OP_ANGLE_C = 5'd14;
  localparam logic [4:0] OP_BIAS_C = 5'd15;
  localparam logic [4:0] OP_AA_C = 5'd16;
  localparam logic [4:0] OP_AB_C = 5'd17;
  localparam logic [4:0] OP_BA_C = 5'd18;
  localparam logic [4:0] OP_BB_C = 5'd19;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] mul_sel;
  } kabf_cmd_t;

  typedef struct packed {
    logic div_done;
  } kabf_status_t;

  // Saturate a 66-bit exact value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

// ===== design/kalman_angle_bias_filter.sv =====
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state angle and gyro-bias Kalman filter in signed fixed point.
// ----------------------------------------------------------------------------
// One request is taken at a time, and the next request is taken in the cycle
// after the result leaves. The two gains each pass through a restoring divider
// that retires one quotient bit a cycle (the default format is Q16.16), and
// the other products share one multiplier, each product followed by its update.
// Configuration writes take effect at once and belong between requests.
module kalman_angle_bias_filter #(
  parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [30:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            measured_angle,
  input  logic signed [31:0]            measured_rate,
  input  logic [16:0]                   time_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            filtered_angle,
  output logic signed [31:0]            unbiased_rate
);
  import kabf_pkg::*;

  kabf_cmd_t cmd;
  kabf_status_t status;

  kabf_control u_control (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  kabf_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .measured_angle(measured_angle), .measured_rate(measured_rate),
    .time_step(time_step), .filtered_angle(filtered_angle),
    .unbiased_rate(unbiased_rate)
  );

endmodule

// ===== design/kabf_datapath.sv =====
// ----------------------------------------------------------------------------
// kabf_datapath
// Filter state, one shared multiplier and a radix-2 divider for the gains.
// ----------------------------------------------------------------------------
module kabf_datapath #(
  parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kabf_pkg::kabf_cmd_t           cmd,
  output kabf_pkg::kabf_status_t        status,
  input  logic                          cfg_write,
  input  logic [kabf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [kabf_pkg::REG_W-1:0]    cfg_data,
  input  logic signed [31:0]            measured_angle,
  input  logic signed [31:0]            measured_rate,
  input  logic [kabf_pkg::DT_W-1:0]     time_step,
  output logic signed [31:0]            filtered_angle,
  output logic signed [31:0]            unbiased_rate
);
  import kabf_pkg::*;

  // Dividend magnitude holds num * 2^FRAC_BITS.
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [REG_W-1:0] RST_QA =
    REG_W'((64'd1 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [REG_W-1:0] RST_QB =
    REG_W'((64'd3 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [REG_W-1:0] RST_R =
    REG_W'((64'd30 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  logic [REG_W-1:0] noise_angle, noise_bias, noise_meas;
  logic signed [31:0] angle, bias, p_aa, p_ab, p_ba, p_bb;
  logic signed [31:0] z, rate, t, s, k0, k1, innov;
  logic signed [32:0] dt;
  logic signed [63:0] prod;

  // Divider registers.
  logic [NUM_W-1:0] quo;
  logic [32:0] rem;
  logic [31:0] dmag;
  logic [CNT_W-1:0] dcnt;
  logic qneg, dzero;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mres;
  logic signed [65:0] pr;
  logic [NUM_W-1:0] nmag;
  logic [31:0] smag;
  logic [32:0] rsh;
  logic signed [NUM_W:0] qs;

  assign pr = 66'(prod);
  assign filtered_angle = angle;
  assign unbiased_rate = rate;
  assign status.div_done = (dcnt == '0);

  // Multiplier operand select.
  always_comb begin
    ma = 33'(rate);
    mb = dt;
    case (cmd.mul_sel)
      MUL_DT_RATE:  begin ma = 33'(rate); mb = dt; end
      MUL_DT_BB:    begin ma = 33'(p_bb); mb = dt; end
      MUL_DT_T:     begin ma = 33'(t); mb = dt; end
      MUL_QB_DT:    begin ma = $signed({2'b00, noise_bias}); mb = dt; end
      MUL_K0_INNOV: begin ma = 33'(k0); mb = 33'(innov); end
      MUL_K1_INNOV: begin ma = 33'(k1); mb = 33'(innov); end
      MUL_K0_AA:    begin ma = 33'(k0); mb = 33'(p_aa); end
      MUL_K0_AB:    begin ma = 33'(k0); mb = 33'(p_ab); end
      MUL_K1_AA:    begin ma = 33'(k1); mb = 33'(p_aa); end
      MUL_K1_AB:    begin ma = 33'(k1); mb = 33'(p_ab); end
      default:      begin ma = 33'(rate); mb = dt; end
    endcase
    mres = 66'(ma * mb) >>> FRAC_BITS;
  end

  // Divider setup and one restoring step.
  always_comb begin
    logic signed [31:0] num;
    logic [31:0] nabs;
    num = (cmd.op == OP_DIV0_START) ? p_aa : p_ba;
    nabs = num[31] ? 32'(-num) : 32'(num);
    nmag = NUM_W'(nabs) << FRAC_BITS;
    smag = s[31] ? 32'(-{s[31], s}) : 32'(s);
    rsh = {rem[31:0], quo[NUM_W-1]};
    qs = qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_angle <= RST_QA;
      noise_bias <= RST_QB;
      noise_meas <= RST_R;
      angle <= '0; bias <= '0;
      p_aa <= '0; p_ab <= '0; p_ba <= '0; p_bb <= '0;
      dcnt <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NOISE_ANGLE:   noise_angle <= cfg_data;
          REG_NOISE_BIAS:    noise_bias <= cfg_data;
          REG_MEASURE_NOISE: noise_meas <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          z <= measured_angle;
          dt <= $signed({16'd0, time_step});
          rate <= sat32(66'(measured_rate) - 66'(bias));
        end
        OP_MUL: prod <= 64'(mres);
        OP_ANGLE_P: angle <= sat32(66'(angle) + pr);
        OP_PRED_T: begin
          t <= sat32(pr - 66'(p_ab) - 66'(p_ba) + $signed({35'd0, noise_angle}));
          p_ab <= sat32(66'(p_ab) - pr);
          p_ba <= sat32(66'(p_ba) - pr);
        end
        OP_AA_P: p_aa <= sat32(66'(p_aa) + pr);
        OP_BB_P: p_bb <= sat32(66'(p_bb) + pr);
        OP_S: s <= sat32(66'(p_aa) + $signed({35'd0, noise_meas}));
        OP_DIV0_START, OP_DIV1_START: begin
          quo <= nmag; rem <= '0; dmag <= smag;
          dzero <= (s == 0);
          qneg <= ((cmd.op == OP_DIV0_START) ? p_aa[31] : p_ba[31]) ^ s[31];
          dcnt <= CNT_W'(NUM_W);
        end
        OP_DIV_STEP: begin
          if (dcnt != '0) begin
            if (rsh >= {1'b0, dmag}) begin
              rem <= rsh - {1'b0, dmag};
              quo <= {quo[NUM_W-2:0], 1'b1};
            end else begin
              rem <= rsh;
              quo <= {quo[NUM_W-2:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        OP_K0: k0 <= dzero ? '0 : sat32(66'(qs));
        OP_K1: k1 <= dzero ? '0 : sat32(66'(qs));
        OP_INNOV: innov <= sat32(66'(z) - 66'(angle));
        OP_ANGLE_C: angle <= sat32(66'(angle) + pr);
        OP_BIAS_C: bias <= sat32(66'(bias) + pr);
        OP_AA_C: p_aa <= sat32(66'(p_aa) - pr);
        OP_AB_C: p_ab <= sat32(66'(p_ab) - pr);
        OP_BA_C: p_ba <= sat32(66'(p_ba) - pr);
        OP_BB_C: p_bb <= sat32(66'(p_bb) - pr);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/kabf_control.sv =====
// ----------------------------------------------------------------------------
// kabf_control
// Sequencer that steps the datapath through predict, gain and correct.
// ----------------------------------------------------------------------------
module kabf_control (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output kabf_pkg::kabf_cmd_t     cmd,
  input  kabf_pkg::kabf_status_t  status
);
  import kabf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] step, step_next;
  logic [4:0] op_at;
  logic [3:0] mul_at;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Fixed micro-program: each multiply step is followed by the step that uses the product.
  // The bias covariance is corrected before the cross term it reads changes.
  always_comb begin
    op_at = OP_NONE;
    mul_at = MUL_DT_RATE;
    case (step)
      5'd0:  begin op_at = OP_MUL; mul_at = MUL_DT_RATE; end
      5'd1:  op_at = OP_ANGLE_P;
      5'd2:  begin op_at = OP_MUL; mul_at = MUL_DT_BB; end
      5'd3:  op_at = OP_PRED_T;
      5'd4:  begin op_at = OP_MUL; mul_at = MUL_DT_T; end
      5'd5:  op_at = OP_AA_P;
      5'd6:  begin op_at = OP_MUL; mul_at = MUL_QB_DT; end
      5'd7:  op_at = OP_BB_P;
      5'd8:  op_at = OP_S;
      5'd9:  op_at = OP_DIV0_START;
      5'd10: op_at = OP_K0;
      5'd11: op_at = OP_DIV1_START;
      5'd12: op_at = OP_K1;
      5'd13: op_at = OP_INNOV;
      5'd14: begin op_at = OP_MUL; mul_at = MUL_K0_INNOV; end
      5'd15: op_at = OP_ANGLE_C;
      5'd16: begin op_at = OP_MUL; mul_at = MUL_K1_INNOV; end
      5'd17: op_at = OP_BIAS_C;
      5'd18: begin op_at = OP_MUL; mul_at = MUL_K1_AB; end
      5'd19: op_at = OP_BB_C;
      5'd20: begin op_at = OP_MUL; mul_at = MUL_K0_AB; end
      5'd21: op_at = OP_AB_C;
      5'd22: begin op_at = OP_MUL; mul_at = MUL_K1_AA; end
      5'd23: op_at = OP_BA_C;
      5'd24: begin op_at = OP_MUL; mul_at = MUL_K0_AA; end
      5'd25: op_at = OP_AA_C;
      default: op_at = OP_NONE;
    endcase
  end

  // Next state and command.
  always_comb begin
    state_next = state;
    step_next = step;
    cmd.op = OP_NONE;
    cmd.mul_sel = mul_at;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_RUN;
          step_next = '0;
        end
      end
      S_RUN: begin
        cmd.op = op_at;
        if (op_at == OP_DIV0_START || op_at == OP_DIV1_START) state_next = S_DIV;
        if (step == 5'd25) state_next = S_OUT;
        step_next = step + 1'b1;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_done) state_next = S_RUN;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule

// ===== test/kabf_checker.sv =====
// ----------------------------------------------------------------------------
// kabf_checker
// Watches the configuration port and both the request and result channels of the filter.
// Predicts each result from its own copy of the filter state and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module kabf_checker
  import kabf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  input  logic [16:0]        time_step,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] filtered_angle,
  input  logic signed [31:0] unbiased_rate,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEFAULT;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } estimate_t;

  // Filter settings and state as the block should hold them.
  logic [30:0] q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
  estimate_t estimate_q[$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact product, floored by the fraction width.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] gain_of(longint num, longint den);
    if (den == 0) return 0;
    return clamp32((num * (64'sd1 <<< FRAC)) / den);
  endfunction

  // One filter update: predict, compute gains, correct.
  task automatic filter_update(input longint z, input longint w, input longint dt,
                               output estimate_t res);
    logic signed [31:0] rate, t, s, k0, k1, innov, aa0, ab0;
    longint dtbb;
    rate = clamp32(w - est_bias);
    est_angle = clamp32(longint'(est_angle) + qmul(dt, rate));
    dtbb = qmul(dt, p_bb);
    t = clamp32(dtbb - p_ab - p_ba + longint'(q_angle));
    p_aa = clamp32(longint'(p_aa) + qmul(dt, t));
    p_ab = clamp32(longint'(p_ab) - dtbb);
    p_ba = clamp32(longint'(p_ba) - dtbb);
    p_bb = clamp32(longint'(p_bb) + qmul(longint'(q_bias), dt));
    s = clamp32(longint'(p_aa) + longint'(r_meas));
    k0 = gain_of(p_aa, s);
    k1 = gain_of(p_ba, s);
    innov = clamp32(z - est_angle);
    est_angle = clamp32(longint'(est_angle) + qmul(k0, innov));
    est_bias = clamp32(longint'(est_bias) + qmul(k1, innov));
    aa0 = p_aa;
    ab0 = p_ab;
    p_aa = clamp32(longint'(p_aa) - qmul(k0, aa0));
    p_ab = clamp32(longint'(p_ab) - qmul(k0, ab0));
    p_ba = clamp32(longint'(p_ba) - qmul(k1, aa0));
    p_bb = clamp32(longint'(p_bb) - qmul(k1, ab0));
    res.angle = est_angle;
    res.rate = rate;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    estimate_t res;
    if (rst) begin
      q_angle <= 31'd66;
      q_bias <= 31'd197;
      r_meas <= 31'd1966;
      est_angle = 0;
      est_bias = 0;
      p_aa = 0;
      p_ab = 0;
      p_ba = 0;
      p_bb = 0;
      estimate_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // Settings; an index past the register list is ignored.
      if (cfg_write) begin
        case (cfg_index)
          REG_NOISE_ANGLE: q_angle <= cfg_data;
          REG_NOISE_BIAS: q_bias <= cfg_data;
          REG_MEASURE_NOISE: r_meas <= cfg_data;
          default: ;
        endcase
      end
      // Compare the returned request with the oldest prediction.
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          report("unexpected result", filtered_angle, 32'h0);
        end else begin
          res = estimate_q.pop_front();
          if (filtered_angle !== res.angle) report("filtered_angle", filtered_angle, res.angle);
          if (unbiased_rate !== res.rate) report("unbiased_rate", unbiased_rate, res.rate);
        end
      end
      // Predict for each accepted request.
      if (in_valid && in_ready) begin
        filter_update(measured_angle, measured_rate, time_step, res);
        estimate_q.push_back(res);
      end
      pending <= estimate_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the angle/bias Kalman filter with directed and random requests
// under several noise settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import kabf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] measured_angle = '0;
  logic signed [31:0] measured_rate = '0;
  logic [16:0] time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] filtered_angle, unbiased_rate;
  int fail_count, pending;
  bit no_idle = 1'b0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  kalman_angle_bias_filter dut (.*);

  kabf_checker chk (.*);

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off when asked.
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (long_hold && hold_left == 0) begin
      hold_left = 600;
      long_hold = 1'b0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= (hold_left == 0);
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 9) < 7);
    end
  end

  // Watchdog: cycles without a handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_noise(input logic [30:0] qa, input logic [30:0] qb,
                           input logic [30:0] r);
    write_reg(REG_NOISE_ANGLE, qa);
    write_reg(REG_NOISE_BIAS, qb);
    write_reg(REG_MEASURE_NOISE, r);
  endtask

  // Ready is sampled between edges, where it holds the value seen at the next edge.
  task automatic send(input logic [31:0] z, input logic [31:0] w, input logic [16:0] dt);
    int gap;
    bit ready_seen;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_angle <= z;
    measured_rate <= w;
    time_step <= dt;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic drain();
    if (in_valid) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    wait (pending == 0 && !out_valid);
    repeat (4) @(posedge clk);
  endtask

  // Mostly sensor-like samples, some fully random words.
  task automatic send_random();
    if ($urandom_range(0, 9) < 7)
      send(32'($urandom_range(0, 400000) - 200000),
           32'($urandom_range(0, 400000) - 200000),
           17'($urandom_range(60, 4000)));
    else
      send(32'($urandom), 32'($urandom), 17'($urandom_range(0, 131071)));
  endtask

  initial begin
    logic [30:0] qa, qb, r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Zero innovation variance: no measurement noise and no elapsed time.
    write_reg(REG_MEASURE_NOISE, 31'd0);
    write_reg(REG_UNUSED, 31'h7fffffff);
    send(32'h7fffffff, 32'h0001_0000, 17'd0);
    send(32'h8000_0000, 32'h8000_0000, 17'd0);
    drain();

    // Default noise, field extremes.
    set_noise(31'd66, 31'd197, 31'd1966);
    send(32'h0, 32'h0, 17'd0);
    send(32'h7fffffff, 32'h7fffffff, 17'h1ffff);
    send(32'h80000000, 32'h80000000, 17'h1ffff);
    send(32'h7fffffff, 32'h80000000, 17'd1);
    send(32'h80000000, 32'h7fffffff, 17'd65536);
    send(32'hffffffff, 32'h00000001, 17'd655);
    send(32'h00010000, 32'hffff0000, 17'd66);
    drain();

    // Largest noise settings, then zero noise.
    set_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send(32'h12345678, 32'hedcba987, 17'h1ffff);
    send(32'h80000000, 32'h7fffffff, 17'd3000);
    send(32'h7fffffff, 32'h0, 17'd1);
    drain();
    set_noise(31'd0, 31'd0, 31'd0);
    send(32'h00020000, 32'h00008000, 17'd655);
    send(32'h80000000, 32'h7fffffff, 17'h1ffff);
    send(32'h0, 32'h0, 17'd0);
    drain();

    // Random phases, each under a noise setting picked by the phase number modulo four.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: begin qa = 31'd66; qb = 31'd197; r = 31'd1966; end
        1: begin qa = 31'($urandom); qb = 31'($urandom); r = 31'($urandom); end
        2: begin
          qa = 31'($urandom_range(0, 2000));
          qb = 31'($urandom_range(0, 2000));
          r = 31'($urandom_range(0, 20000));
        end
        default: begin qa = 31'h7fffffff; qb = 31'($urandom_range(0, 7)); r = 31'd0; end
      endcase
      set_noise(qa, qb, r);
      no_idle = (ph == 3);
      for (int n = 0; n < 150; n++) begin
        if (ph == 2 && n == 20) long_hold = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
